### rtl/hlsrgb_pkg.sv
package hlsrgb_pkg;

    // number formats
    localparam int HUE_FRAC_BITS   = 6;
    localparam int LEVEL_FRAC_BITS = 15;
    localparam int HUE_W           = 15;
    localparam int LVL_W           = 16;

    // hue landmarks in hue units
    localparam int DEG60  = 60 << HUE_FRAC_BITS;
    localparam int DEG120 = 120 << HUE_FRAC_BITS;
    localparam int DEG180 = 180 << HUE_FRAC_BITS;
    localparam int DEG240 = 240 << HUE_FRAC_BITS;
    localparam int DEG360 = 360 << HUE_FRAC_BITS;

    // level landmarks
    localparam int LVL_ONE  = 1 << LEVEL_FRAC_BITS;
    localparam int LVL_HALF = 1 << (LEVEL_FRAC_BITS - 1);

    // ramp datapath widths
    localparam int SPAN_W   = LVL_W + 1;
    localparam int FAC_W    = $clog2(DEG60 + 1);
    localparam int PROD_W   = SPAN_W + FAC_W;
    localparam int RECIP_SH = PROD_W + FAC_W;
    localparam int RECIP_W  = RECIP_SH - FAC_W + 1;

    // reciprocal of the 60 degree span, exact floor division for PROD_W-bit operands
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(DEG60) - 64'd1) / 64'(DEG60));

    // register stages from input to output
    localparam int PIPE_DEPTH = 6;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [LVL_W-1:0] lightness;
        logic [LVL_W-1:0] saturation;
    } t_hls_in;

    typedef struct packed {
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
    } t_rgb_out;

    // piece of the channel hue curve
    typedef enum logic [1:0] {
        REG_UP,
        REG_HI,
        REG_DOWN,
        REG_LO
    } t_region;

    // stage load enables shared with the channel slices
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } t_pipe_en;

endpackage

### rtl/hlsrgb_chan.sv
module hlsrgb_chan (
    input  logic                                i_clk,
    input  hlsrgb_pkg::t_pipe_en                i_en,
    input  logic [hlsrgb_pkg::HUE_W-1:0]        i_hue,
    input  logic [hlsrgb_pkg::SPAN_W-1:0]       i_span,
    input  logic [hlsrgb_pkg::SPAN_W-1:0]       i_hi,
    input  logic [hlsrgb_pkg::SPAN_W-1:0]       i_lo,
    input  logic                                i_gray,
    input  logic [hlsrgb_pkg::LVL_W-1:0]        i_l,
    output logic [hlsrgb_pkg::LVL_W-1:0]        o_level
);
    import hlsrgb_pkg::*;

    t_region                    n_reg2;
    logic [FAC_W-1:0]           n_fac2;
    t_region                    r_reg2, r_reg3, r_reg4, r_reg5;
    logic [FAC_W-1:0]           r_fac2, r_fac3;
    logic [PROD_W-1:0]          n_prod4, r_prod4;
    logic [PROD_W+RECIP_W-1:0]  w_scaled;
    logic [SPAN_W-1:0]          r_quo5;
    logic [SPAN_W-1:0]          w_ramp;
    logic [LVL_W-1:0]           n_level6, r_level6;

    // classify the wrapped hue and form the ramp factor
    always_comb begin
        priority if (i_hue < DEG60) begin
            n_reg2 = REG_UP;
            n_fac2 = FAC_W'(i_hue);
        end else if (i_hue < DEG180) begin
            n_reg2 = REG_HI;
            n_fac2 = '0;
        end else if (i_hue < DEG240) begin
            n_reg2 = REG_DOWN;
            n_fac2 = FAC_W'(DEG240 - int'(i_hue));
        end else begin
            n_reg2 = REG_LO;
            n_fac2 = '0;
        end
    end

    // span times factor, then floor division by the 60 degree span
    assign n_prod4  = i_span * r_fac3;
    assign w_scaled = r_prod4 * RECIP;

    // pick the level for this channel
    assign w_ramp = i_lo + r_quo5;
    always_comb begin
        if (i_gray) begin
            n_level6 = i_l;
        end else begin
            unique case (r_reg5)
                REG_UP, REG_DOWN: n_level6 = w_ramp[LVL_W-1:0];
                REG_HI:           n_level6 = i_hi[LVL_W-1:0];
                REG_LO:           n_level6 = i_lo[LVL_W-1:0];
            endcase
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_reg2 <= n_reg2;
            r_fac2 <= n_fac2;
        end
        if (i_en.en3) begin
            r_reg3 <= r_reg2;
            r_fac3 <= r_fac2;
        end
        if (i_en.en4) begin
            r_reg4  <= r_reg3;
            r_prod4 <= n_prod4;
        end
        if (i_en.en5) begin
            r_reg5 <= r_reg4;
            r_quo5 <= w_scaled[RECIP_SH +: SPAN_W];
        end
        if (i_en.en6) begin
            r_level6 <= n_level6;
        end
    end

    assign o_level = r_level6;

endmodule

### rtl/hls_to_rgb_converter_unit.sv
// HLS to RGB converter: takes one hue/lightness/saturation transaction per clock and returns
// one red/green/blue transaction per clock at full throughput while the output is not stalled.
// The datapath is built from six register stages, in order: hue wrap and clamp,
// level multiply, m1/m2 forming, ramp multiply, reciprocal division by the 60 degree span,
// and final channel selection into the output register. Each stage holds its own valid bit,
// so bubbles are squeezed out while the output is stalled and input keeps flowing until
// all six stages are full. Hue is in 1/64 degree, levels are Q1.15 with 32768 as 1.0;
// lightness and saturation above 1.0 are clamped, zero saturation gives gray.
module hls_to_rgb_converter_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hlsrgb_pkg::t_hls_in   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hlsrgb_pkg::t_rgb_out  o_data
);
    import hlsrgb_pkg::*;

    logic [PIPE_DEPTH-1:0]      r_vld;
    logic [PIPE_DEPTH-1:0]      w_en;
    t_pipe_en                   w_pen;

    // stage 1 signals
    logic [LVL_W-1:0]           n_l1, n_s1, r_l1, r_s1;
    logic                       r_gray1;
    logic [HUE_W:0]             w_rsum;
    logic [HUE_W-1:0]           w_bsub;
    logic [HUE_W-1:0]           n_rh1, n_gh1, n_bh1, r_rh1, r_gh1, r_bh1;

    // stage 2 signals
    logic                       n_sel2, r_sel2;
    logic [SPAN_W-1:0]          w_mb;
    logic [LVL_W+SPAN_W-1:0]    n_prod2, r_prod2;
    logic [LVL_W-1:0]           r_l2, r_s2;
    logic                       r_gray2;

    // stage 3 signals
    logic [SPAN_W-1:0]          w_sh, n_hi3, n_lo3, r_hi3, r_lo3, r_span3;
    logic [LVL_W-1:0]           r_l3;
    logic                       r_gray3;

    // stage 4 and 5 carry
    logic [SPAN_W-1:0]          r_hi4, r_lo4, r_hi5, r_lo5;
    logic [LVL_W-1:0]           r_l4, r_l5;
    logic                       r_gray4, r_gray5;

    // per-stage enables, a stage loads when empty or when the next one loads
    always_comb begin
        w_en[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || i_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign w_pen.en2 = w_en[1];
    assign w_pen.en3 = w_en[2];
    assign w_pen.en4 = w_en[3];
    assign w_pen.en5 = w_en[4];
    assign w_pen.en6 = w_en[5];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[PIPE_DEPTH-1];

    // clamp levels to 1.0
    assign n_l1 = (i_data.lightness > LVL_ONE) ? LVL_W'(LVL_ONE) : i_data.lightness;
    assign n_s1 = (i_data.saturation > LVL_ONE) ? LVL_W'(LVL_ONE) : i_data.saturation;

    // channel hues wrapped into 0..360, 360 itself kept
    assign w_rsum = {1'b0, i_data.hue} + (HUE_W+1)'(DEG120);
    assign n_rh1  = (w_rsum > DEG360) ? HUE_W'(int'(w_rsum) - DEG360) : w_rsum[HUE_W-1:0];
    assign n_gh1  = (i_data.hue > DEG360) ? HUE_W'(int'(i_data.hue) - DEG360) : i_data.hue;
    assign w_bsub = HUE_W'(int'(i_data.hue) - DEG120);
    always_comb begin
        if (i_data.hue >= DEG120) begin
            n_bh1 = (w_bsub > DEG360) ? HUE_W'(int'(w_bsub) - DEG360) : w_bsub;
        end else begin
            n_bh1 = HUE_W'(int'(i_data.hue) + DEG360 - DEG120);
        end
    end

    // m2 product: l*(1+s) in the lower half, l*s above
    assign n_sel2  = (r_l1 <= LVL_HALF);
    assign w_mb    = n_sel2 ? (SPAN_W'(LVL_ONE) + {1'b0, r_s1}) : {1'b0, r_s1};
    assign n_prod2 = r_l1 * w_mb;

    // m2, m1 and their span
    assign w_sh  = r_prod2[LEVEL_FRAC_BITS +: SPAN_W];
    assign n_hi3 = r_sel2 ? w_sh : ({1'b0, r_l2} + {1'b0, r_s2} - w_sh);
    assign n_lo3 = {r_l2, 1'b0} - n_hi3;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_l1    <= n_l1;
            r_s1    <= n_s1;
            r_gray1 <= (n_s1 == '0);
            r_rh1   <= n_rh1;
            r_gh1   <= n_gh1;
            r_bh1   <= n_bh1;
        end
        if (w_en[1]) begin
            r_prod2 <= n_prod2;
            r_sel2  <= n_sel2;
            r_l2    <= r_l1;
            r_s2    <= r_s1;
            r_gray2 <= r_gray1;
        end
        if (w_en[2]) begin
            r_hi3   <= n_hi3;
            r_lo3   <= n_lo3;
            r_span3 <= n_hi3 - n_lo3;
            r_l3    <= r_l2;
            r_gray3 <= r_gray2;
        end
        if (w_en[3]) begin
            r_hi4   <= r_hi3;
            r_lo4   <= r_lo3;
            r_l4    <= r_l3;
            r_gray4 <= r_gray3;
        end
        if (w_en[4]) begin
            r_hi5   <= r_hi4;
            r_lo5   <= r_lo4;
            r_l5    <= r_l4;
            r_gray5 <= r_gray4;
        end
    end

    // one slice per channel
    hlsrgb_chan u_red (
        .i_clk   (i_clk),
        .i_en    (w_pen),
        .i_hue   (r_rh1),
        .i_span  (r_span3),
        .i_hi    (r_hi5),
        .i_lo    (r_lo5),
        .i_gray  (r_gray5),
        .i_l     (r_l5),
        .o_level (o_data.red)
    );

    hlsrgb_chan u_green (
        .i_clk   (i_clk),
        .i_en    (w_pen),
        .i_hue   (r_gh1),
        .i_span  (r_span3),
        .i_hi    (r_hi5),
        .i_lo    (r_lo5),
        .i_gray  (r_gray5),
        .i_l     (r_l5),
        .o_level (o_data.green)
    );

    hlsrgb_chan u_blue (
        .i_clk   (i_clk),
        .i_en    (w_pen),
        .i_hue   (r_bh1),
        .i_span  (r_span3),
        .i_hi    (r_hi5),
        .i_lo    (r_lo5),
        .i_gray  (r_gray5),
        .i_l     (r_l5),
        .o_level (o_data.blue)
    );

endmodule

### rtl/hlsrgb_check.sv
module hlsrgb_check (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input hlsrgb_pkg::t_hls_in   i_data,
    input logic                  o_valid,
    input logic                  i_ready,
    input hlsrgb_pkg::t_rgb_out  o_data
);
    import hlsrgb_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             w_in_acc, w_out_acc;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    // transactions in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (!w_in_acc && w_out_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // no output right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled output changed");

    // never more in flight than stages
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than stages");

    // every result comes from an accepted item
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("output without accepted input");

    // intensities stay within 1.0
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.red <= LVL_ONE) && (o_data.green <= LVL_ONE)
                    && (o_data.blue <= LVL_ONE))
        else $error("intensity above 1.0");

endmodule

bind hls_to_rgb_converter_unit hlsrgb_check u_check (.*);
